[sv/spi_master_byte_shifter_unit_defines.svh]
// Assertion macros used by the SPI master byte shifter checker.
`ifndef SPI_MASTER_BYTE_SHIFTER_UNIT_DEFINES_SVH
`define SPI_MASTER_BYTE_SHIFTER_UNIT_DEFINES_SVH

// Check a property on every clock edge outside of reset.
`define SMBS_ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define SMBS_ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/smbs_pkg.sv]
// Shared types, constants and helpers of the SPI master byte shifter.
package smbs_pkg;

  localparam int BYTE_W      = 8;
  localparam int DIV_SEL_W   = 3;
  localparam int HALF_W      = 8;
  localparam int PRESCALE_W  = 7;
  localparam int BIT_CNT_W   = 4;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 3;
  localparam int IN_DATA_W   = 16;
  localparam int OUT_DATA_W  = 16;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPOL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPHA     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LSB      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIV_SEL  = 3'd4;

  // Divider select codes
  localparam logic [DIV_SEL_W-1:0] DIV_SEL_RESET   = 3'd1;
  localparam logic [DIV_SEL_W-1:0] DIV_SEL_UNUSED  = 3'd7;

  typedef struct packed {
    logic                 enable;
    logic                 clock_polarity;
    logic                 clock_phase;
    logic                 lsb_first;
    logic [DIV_SEL_W-1:0] clock_divider_select;
  } cfg_t;

  typedef struct packed {
    logic              sck;
    logic              mosi;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] rx_byte;
  } res_t;

  // Half period of SCK in system clocks; the unused code runs as divide by 4.
  function automatic logic [HALF_W-1:0] half_period(input logic [DIV_SEL_W-1:0] sel);
    logic [DIV_SEL_W-1:0] s;
    s = (sel == DIV_SEL_UNUSED) ? DIV_SEL_RESET : sel;
    return HALF_W'(1) << s;
  endfunction

endpackage

[sv/spi_master_byte_shifter_unit.sv]
// Top level of the SPI master byte shifter.
// Usage:
//   Each input beat is one system clock tick. in_tuser is the start request,
//   in_tdata carries the byte to send and the sampled MISO level. A start is
//   taken only when the block is idle and enabled; otherwise it is ignored.
//   Each input beat yields exactly one output beat with the SCK and MOSI
//   levels, busy, the last received byte, and out_tlast as the one-beat done
//   pulse at the end of a frame.
//   One beat is taken every cycle while in_tready is high; each result
//   is registered in the output buffer after the shift logic.
//   A two-entry output buffer absorbs results while the receiver stalls;
//   once both entries are full, in_tready drops until the next out_tready.
//   Configuration writes on the cfg channel are taken every cycle and should
//   be issued only while no transfer is running.
//   Reset (synchronous, active low) clears the shifter, empties the output
//   buffer and sets the divider select to divide by 4.
module spi_master_byte_shifter_unit #(
  parameter int FRAME_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [smbs_pkg::IN_DATA_W-1:0]    in_tdata,  // tx_byte[7:0], miso[8], zero pad
  input  logic                              in_tuser,  // start_req
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [smbs_pkg::OUT_DATA_W-1:0]   out_tdata, // sck, mosi, busy_res, rx_byte[10:3]
  output logic                              out_tlast, // done_res
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [smbs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [smbs_pkg::CFG_DATA_W-1:0]   cfg_data
);

  smbs_pkg::cfg_t cfg;
  smbs_pkg::res_t step_res;
  smbs_pkg::res_t buf_res;
  logic           step_en;

  assign step_en = in_tvalid && in_tready;

  smbs_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  smbs_shift_core #(
    .FRAME_BITS (FRAME_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step_en   (step_en),
    .start_req (in_tuser),
    .tx_byte   (in_tdata[smbs_pkg::BYTE_W-1:0]),
    .miso      (in_tdata[smbs_pkg::BYTE_W]),
    .res       (step_res)
  );

  smbs_out_buf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (step_en),
    .wr_res   (step_res),
    .has_room (in_tready),
    .rd_valid (out_tvalid),
    .rd_en    (out_tready),
    .rd_res   (buf_res)
  );

  // Pack the result beat
  always_comb begin
    out_tdata    = '0;
    out_tdata[0] = buf_res.sck;
    out_tdata[1] = buf_res.mosi;
    out_tdata[2] = buf_res.busy_res;
    out_tdata[smbs_pkg::BYTE_W+2:3] = buf_res.rx_byte;
    out_tlast    = buf_res.done_res;
  end

endmodule

[sv/smbs_cfg_regs.sv]
// Configuration registers of the SPI master byte shifter.
module smbs_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [smbs_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [smbs_pkg::CFG_DATA_W-1:0]  cfg_data,
  output smbs_pkg::cfg_t                   cfg
);

  smbs_pkg::cfg_t cfg_r;

  assign cfg_ready = 1'b1;
  assign cfg         = cfg_r;

  // Write one register per beat; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.enable               <= 1'b0;
      cfg_r.clock_polarity       <= 1'b0;
      cfg_r.clock_phase          <= 1'b0;
      cfg_r.lsb_first            <= 1'b0;
      cfg_r.clock_divider_select <= smbs_pkg::DIV_SEL_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        smbs_pkg::REG_ENABLE:  cfg_r.enable         <= cfg_data[0];
        smbs_pkg::REG_CPOL:    cfg_r.clock_polarity <= cfg_data[0];
        smbs_pkg::REG_CPHA:    cfg_r.clock_phase    <= cfg_data[0];
        smbs_pkg::REG_LSB:     cfg_r.lsb_first      <= cfg_data[0];
        smbs_pkg::REG_DIV_SEL: cfg_r.clock_divider_select <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

[sv/smbs_shift_core.sv]
// Prescaler, SCK phase and shift registers of the SPI master byte shifter.
module smbs_shift_core #(
  parameter int FRAME_BITS = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  smbs_pkg::cfg_t                cfg,
  input  logic                          step_en,
  input  logic                          start_req,
  input  logic [smbs_pkg::BYTE_W-1:0]   tx_byte,
  input  logic                          miso,
  output smbs_pkg::res_t                res
);

  localparam int LOAD_W = (FRAME_BITS < smbs_pkg::BYTE_W) ? FRAME_BITS : smbs_pkg::BYTE_W;
  localparam logic [smbs_pkg::BIT_CNT_W:0] FRAME_LIMIT = (smbs_pkg::BIT_CNT_W+1)'(FRAME_BITS);

  logic [FRAME_BITS-1:0]            tx_shift_r, tx_shift_nxt;
  logic [FRAME_BITS-1:0]            rx_shift_r, rx_shift_nxt;
  logic [smbs_pkg::BIT_CNT_W-1:0]   bit_count_r, bit_count_nxt;
  logic [smbs_pkg::PRESCALE_W-1:0]  prescale_r, prescale_nxt;
  logic                             edge_phase_r, edge_phase_nxt;
  logic                             in_transfer_r, in_transfer_nxt;
  logic [smbs_pkg::BYTE_W-1:0]      received_r, received_nxt;

  logic [FRAME_BITS-1:0]            tx_load;
  logic [FRAME_BITS-1:0]            tx_adv;
  logic [FRAME_BITS-1:0]            rx_smp;
  logic [smbs_pkg::PRESCALE_W-1:0]  prescale_inc;
  logic [smbs_pkg::BIT_CNT_W-1:0]   bit_count_inc;
  logic                             half_done;
  logic                             frame_done;
  logic                             done;
  logic [smbs_pkg::BYTE_W-1:0]      rx_low;

  // Frame to send, truncated or zero filled to the frame width
  always_comb begin
    tx_load = '0;
    tx_load[LOAD_W-1:0] = tx_byte[LOAD_W-1:0];
  end

  // Shift and sample in the configured bit order
  assign tx_adv = cfg.lsb_first ? (tx_shift_r >> 1) : (tx_shift_r << 1);
  assign rx_smp = cfg.lsb_first ? {miso, rx_shift_r[FRAME_BITS-1:1]}
                                : {rx_shift_r[FRAME_BITS-2:0], miso};

  assign prescale_inc  = prescale_r + 1'b1;
  assign half_done     = {1'b0, prescale_inc} >= smbs_pkg::half_period(cfg.clock_divider_select);
  assign bit_count_inc = bit_count_r + 1'b1;
  assign frame_done    = (bit_count_inc == '0) || ({1'b0, bit_count_inc} >= FRAME_LIMIT);

  // Low byte of the frame just received
  always_comb begin
    rx_low = '0;
    rx_low[LOAD_W-1:0] = rx_shift_nxt[LOAD_W-1:0];
  end

  // Next state for one system tick
  always_comb begin
    tx_shift_nxt    = tx_shift_r;
    rx_shift_nxt    = rx_shift_r;
    bit_count_nxt   = bit_count_r;
    prescale_nxt    = prescale_r;
    edge_phase_nxt  = edge_phase_r;
    in_transfer_nxt = in_transfer_r;
    done            = 1'b0;
    if (!in_transfer_r) begin
      if (start_req && cfg.enable) begin
        tx_shift_nxt    = tx_load;
        rx_shift_nxt    = '0;
        bit_count_nxt   = '0;
        prescale_nxt    = '0;
        edge_phase_nxt  = 1'b0;
        in_transfer_nxt = 1'b1;
      end
    end else if (!cfg.enable) begin
      in_transfer_nxt = 1'b0;
      edge_phase_nxt  = 1'b0;
      prescale_nxt    = '0;
      bit_count_nxt   = '0;
    end else if (!half_done) begin
      prescale_nxt = prescale_inc;
    end else begin
      prescale_nxt = '0;
      if (!edge_phase_r) begin
        // Leading edge
        if (!cfg.clock_phase) begin
          rx_shift_nxt = rx_smp;
        end else if (bit_count_r != '0) begin
          tx_shift_nxt = tx_adv;
        end
        edge_phase_nxt = 1'b1;
      end else begin
        // Trailing edge
        if (cfg.clock_phase) begin
          rx_shift_nxt = rx_smp;
        end
        edge_phase_nxt = 1'b0;
        bit_count_nxt  = bit_count_inc;
        if (frame_done) begin
          in_transfer_nxt = 1'b0;
          bit_count_nxt   = '0;
          done            = 1'b1;
        end else if (!cfg.clock_phase) begin
          tx_shift_nxt = tx_adv;
        end
      end
    end
  end

  assign received_nxt = done ? rx_low : received_r;

  // Advance state on each accepted beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_shift_r    <= '0;
      rx_shift_r    <= '0;
      bit_count_r   <= '0;
      prescale_r    <= '0;
      edge_phase_r  <= 1'b0;
      in_transfer_r <= 1'b0;
      received_r    <= '0;
    end else if (step_en) begin
      tx_shift_r    <= tx_shift_nxt;
      rx_shift_r    <= rx_shift_nxt;
      bit_count_r   <= bit_count_nxt;
      prescale_r    <= prescale_nxt;
      edge_phase_r  <= edge_phase_nxt;
      in_transfer_r <= in_transfer_nxt;
      received_r    <= received_nxt;
    end
  end

  // Line levels after the tick
  always_comb begin
    res.sck      = in_transfer_nxt ? (cfg.clock_polarity ^ edge_phase_nxt)
                                   : cfg.clock_polarity;
    res.mosi     = in_transfer_nxt &
                   (cfg.lsb_first ? tx_shift_nxt[0] : tx_shift_nxt[FRAME_BITS-1]);
    res.busy_res = in_transfer_nxt;
    res.done_res = done;
    res.rx_byte  = received_nxt;
  end

endmodule

[sv/smbs_out_buf.sv]
// Two-entry result buffer that decouples the input side from output stalls.
module smbs_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            wr_en,
  input  smbs_pkg::res_t  wr_res,
  output logic            has_room,
  output logic            rd_valid,
  input  logic            rd_en,
  output smbs_pkg::res_t  rd_res
);

  smbs_pkg::res_t slot_r [2];
  logic           wr_ptr_r, rd_ptr_r;
  logic [1:0]     count_r;
  logic           push, pop;

  assign has_room = (count_r != 2'd2);
  assign rd_valid = (count_r != 2'd0);
  assign push     = wr_en && has_room;
  assign pop      = rd_en && rd_valid;
  assign rd_res   = slot_r[rd_ptr_r];

  // Store results
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_res;
    end
  end

  // Track fill level and pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (pop)  rd_ptr_r <= ~rd_ptr_r;
      count_r <= count_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

[sv/smbs_checker.sv]
// Port-level checks of the SPI master byte shifter, bound to the top level.
`include "spi_master_byte_shifter_unit_defines.svh"

module smbs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [smbs_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic                             out_tlast
);

  // Stalled result beat holds
  `SMBS_ASSERT_CLK(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast), "stalled output beat changed")

  // Done ends the transfer in the same beat
  `SMBS_ASSERT_CLK(a_done_idle, out_tvalid && out_tlast |-> !out_tdata[2], "done shown while busy")

  // MOSI rests low while idle
  `SMBS_ASSERT_CLK(a_mosi_idle, out_tvalid && !out_tdata[2] |-> !out_tdata[1], "mosi high while idle")

  // Reset empties the result buffer
  `SMBS_ASSERT_RST(a_rst_empty, !rst_n |=> !out_tvalid, "output valid after reset")

endmodule

bind spi_master_byte_shifter_unit smbs_checker u_smbs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
